// ===== src/csem_pkg.sv =====
// Shared types and constants for the counting semaphore block.
`default_nettype none
package csem_pkg;

  localparam int CMD_W    = 3;
  localparam int TID_W    = 8;
  localparam int LEVEL_W  = 16;
  localparam int STATUS_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT    = 3'd0,
    CMD_PEND    = 3'd1,
    CMD_POST    = 3'd2,
    CMD_TRY     = 3'd3,
    CMD_DESTROY = 3'd4
  } cmd_t;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BLOCKED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_LOCKED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNINIT   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd5;

  localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = 16'sh7FFF;

  // Classified request handed from the front to the back.
  typedef struct packed {
    cmd_t             cmd;
    logic [TID_W-1:0] thread_id;
  } req_t;

  // One result item.
  typedef struct packed {
    logic                      last;
    logic signed [LEVEL_W-1:0] level_value;
    logic [TID_W-1:0]          woken_thread;
    logic                      woken_valid;
    logic [STATUS_W-1:0]       status;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_WAKE     = 4'b0010,
    S_DRAIN    = 4'b0100,
    S_DRAIN_RD = 4'b1000
  } back_state_t;

endpackage
`default_nettype wire

// ===== src/csem_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module csem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/csem_front.sv =====
// Front end: accept requests, drop undefined commands, buffer in a two-entry queue.
`default_nettype none
module csem_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [csem_pkg::CMD_W-1:0] in_cmd,
  input  wire logic [csem_pkg::TID_W-1:0] in_tid,
  output logic                       req_valid,
  input  wire logic                  req_ready,
  output csem_pkg::req_t             req
);
  import csem_pkg::*;

  req_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  logic       known;

  always_comb begin
    case (in_cmd)
      CMD_INIT, CMD_PEND, CMD_POST, CMD_TRY, CMD_DESTROY: known = 1'b1;
      default: known = 1'b0;
    endcase
  end

  assign in_ready  = (count != 2'd2);
  assign push      = in_valid && in_ready && known;
  assign req_valid = (count != 2'd0);
  assign pop       = req_valid && req_ready;
  assign req       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{cmd: cmd_t'(in_cmd), thread_id: in_tid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/csem_back.sv =====
// Back end: semaphore state, wait queue, command execution and result register.
`default_nettype none
module csem_back #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic signed [csem_pkg::LEVEL_W-1:0] initial_level,
  input  wire logic                          req_valid,
  output logic                               req_ready,
  input  wire csem_pkg::req_t                req,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output csem_pkg::result_t                  res
);
  import csem_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  back_state_t               state, state_next;
  logic signed [LEVEL_W-1:0] level, level_next;
  logic                      initialized, initialized_next;
  logic [PTR_W-1:0]          head, head_next;
  logic [PTR_W-1:0]          tail, tail_next;
  logic [CNT_W-1:0]          count, count_next;
  logic                      emit;
  result_t                   item;
  logic                      out_space;
  logic                      we;
  logic [TID_W-1:0]          rd_data;
  logic signed [LEVEL_W-1:0] level_inc;
  logic                      level_pos;

  assign out_space = !res_valid || res_ready;
  assign req_ready = (state == S_IDLE) && out_space;
  assign level_pos = !level[LEVEL_W-1] && (level != '0);
  assign level_inc = (level == LEVEL_MAX) ? level : level + 16'sd1;

  csem_ram #(
    .WIDTH (TID_W),
    .DEPTH (QUEUE_DEPTH),
    .AW    (PTR_W)
  ) u_queue (
    .clk   (clk),
    .we    (we),
    .waddr (tail),
    .wdata (req.thread_id),
    .raddr (head),
    .rdata (rd_data)
  );

  always_comb begin
    state_next       = state;
    level_next       = level;
    initialized_next = initialized;
    head_next        = head;
    tail_next        = tail;
    count_next       = count;
    emit             = 1'b0;
    we               = 1'b0;
    item             = '{last: 1'b1, level_value: '0, woken_thread: '0,
                         woken_valid: 1'b0, status: ST_OK};
    case (state)
      S_IDLE: begin
        if (req_valid && out_space) begin
          if (req.cmd == CMD_INIT) begin
            level_next       = initial_level;
            head_next        = '0;
            tail_next        = '0;
            count_next       = '0;
            initialized_next = 1'b1;
            emit             = 1'b1;
          end else if (!initialized) begin
            item.status = ST_UNINIT;
            emit        = 1'b1;
          end else begin
            case (req.cmd)
              CMD_PEND: begin
                emit = 1'b1;
                if (level_pos) begin
                  level_next = level - 16'sd1;
                end else if (count >= CNT_FULL) begin
                  item.status = ST_FULL;
                end else begin
                  we          = 1'b1;
                  tail_next   = (tail == PTR_LAST) ? '0 : tail + PTR_ONE;
                  count_next  = count + CNT_ONE;
                  item.status = ST_BLOCKED;
                end
              end
              CMD_POST: begin
                level_next = level_inc;
                if (!level_inc[LEVEL_W-1] && (level_inc != '0) && (count != '0)) begin
                  state_next = S_WAKE;
                end else begin
                  emit = 1'b1;
                end
              end
              CMD_TRY: begin
                emit = 1'b1;
                if (level_pos) begin
                  level_next       = level - 16'sd1;
                  item.level_value = level - 16'sd1;
                end else begin
                  item.status      = ST_LOCKED;
                  item.level_value = level;
                end
              end
              CMD_DESTROY: begin
                initialized_next = 1'b0;
                if (count == '0) begin
                  head_next = '0;
                  tail_next = '0;
                  emit      = 1'b1;
                end else begin
                  state_next = S_DRAIN;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      S_WAKE: begin
        if (out_space) begin
          emit              = 1'b1;
          item.woken_valid  = 1'b1;
          item.woken_thread = rd_data;
          level_next        = level - 16'sd1;
          head_next         = (head == PTR_LAST) ? '0 : head + PTR_ONE;
          count_next        = count - CNT_ONE;
          state_next        = S_IDLE;
        end
      end
      S_DRAIN: begin
        if (out_space) begin
          emit              = 1'b1;
          item.status       = ST_RELEASED;
          item.woken_valid  = 1'b1;
          item.woken_thread = rd_data;
          item.last         = (count == CNT_ONE);
          count_next        = count - CNT_ONE;
          if (count == CNT_ONE) begin
            head_next  = '0;
            tail_next  = '0;
            state_next = S_IDLE;
          end else begin
            head_next  = (head == PTR_LAST) ? '0 : head + PTR_ONE;
            state_next = S_DRAIN_RD;
          end
        end
      end
      S_DRAIN_RD: begin
        state_next = S_DRAIN;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      level       <= '0;
      initialized <= 1'b0;
      head        <= '0;
      tail        <= '0;
      count       <= '0;
      res_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      level       <= level_next;
      initialized <= initialized_next;
      head        <= head_next;
      tail        <= tail_next;
      count       <= count_next;
      if (emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res <= item;
    end
  end

endmodule
`default_nettype wire

// ===== src/counting_semaphore_fifo_waiters_top.sv =====
// Top level of the counting semaphore with a FIFO of waiting threads.
//
//  channel  | direction | payload
//  ---------+-----------+-------------------------------------------------
//  s_axis   | in        | tdata: command[2:0], thread_id[10:3], zero pad
//  m_axis   | out       | tdata: woken_thread, level_value; tuser: status,
//           |           | woken_valid; tlast: last result of a request
//  cfg      | in        | data: initial_level
//
// Init, pend, try-pend and a post that wakes nobody are answered from the back end's idle state;
// a post that wakes a waiter is answered from the wake state, after the wait-queue RAM read.
// Destroy answers from idle with an empty queue, else drains with one RAM read per waiter.
// Reset clears level, flag and queue pointers; queue contents need no clearing.
// A two-entry request queue lets the input run ahead while the output stalls.
`default_nettype none
module counting_semaphore_fifo_waiters_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // command[2:0], thread_id[10:3], zeros[15:11]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // woken_thread[7:0], level_value[23:8]
  output logic [3:0]       m_axis_tuser,   // status[2:0], woken_valid[3]
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data        // initial_level
);
  import csem_pkg::*;

  logic signed [LEVEL_W-1:0] initial_level;
  logic                      req_valid;
  logic                      req_ready;
  req_t                      req;
  result_t                   res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_level <= '0;
    end else if (cfg_valid && cfg_ready) begin
      initial_level <= cfg_data;
    end
  end

  csem_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_cmd    (s_axis_tdata[2:0]),
    .in_tid    (s_axis_tdata[10:3]),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req)
  );

  csem_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .initial_level (initial_level),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .req           (req),
    .res_valid     (m_axis_tvalid),
    .res_ready     (m_axis_tready),
    .res           (res)
  );

  assign m_axis_tdata = {res.level_value, res.woken_thread};
  assign m_axis_tuser = {res.woken_valid, res.status};
  assign m_axis_tlast = res.last;

endmodule
`default_nettype wire
